[rtl/core/wocf_pkg.sv]
// types and constants shared by the waypoint obstacle clearance filter
package wocf_pkg;

  localparam int COORD_BITS  = 24;
  localparam int RADIUS_BITS = 52;
  localparam int DATA_BITS   = 64;
  localparam int ADDR_BITS   = 4;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * DIFF_BITS;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1638400);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TEST  = 2'd2
  } op_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0] opcode;
    coord_t     pos_x;
    coord_t     pos_y;
    coord_t     pos_z;
  } in_item_t;

  typedef struct packed {
    coord_t route_x;
    coord_t route_y;
    coord_t route_z;
    logic   keep;
  } out_item_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   hit;
  } token_t;

endpackage

[rtl/core/wocf_cell.sv]
// one obstacle slot with its distance check, passes the waypoint token onward
module wocf_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             wr_en_i,
  input  logic                             ent_valid_i,
  input  wocf_pkg::coord_t                 wr_x_i,
  input  wocf_pkg::coord_t                 wr_y_i,
  input  wocf_pkg::coord_t                 wr_z_i,
  input  logic [wocf_pkg::RADIUS_BITS-1:0] radius_i,
  input  wocf_pkg::token_t                 tok_i,
  output wocf_pkg::token_t                 tok_o
);
  import wocf_pkg::*;

  function automatic logic [SQ_BITS-1:0] sq_diff(coord_t a, coord_t b);
    logic [DIFF_BITS-1:0] d;
    logic [DIFF_BITS-1:0] m;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[DIFF_BITS-1] ? (~d + DIFF_BITS'(1)) : d;
    return SQ_BITS'(m) * SQ_BITS'(m);
  endfunction

  coord_t ent_x_q, ent_y_q, ent_z_q;
  logic   valid_q;
  coord_t x_q, y_q, z_q;
  logic   hit_q;
  logic [SQ_BITS-1:0] sqx_q, sqy_q, sqz_q;
  logic [RADIUS_BITS-1:0] dist_sq;
  logic close;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ent_x_q <= wr_x_i;
      ent_y_q <= wr_y_i;
      ent_z_q <= wr_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q   <= tok_i.x;
      y_q   <= tok_i.y;
      z_q   <= tok_i.z;
      hit_q <= tok_i.hit;
      sqx_q <= sq_diff(tok_i.x, ent_x_q);
      sqy_q <= sq_diff(tok_i.y, ent_y_q);
      sqz_q <= sq_diff(tok_i.z, ent_z_q);
    end
  end

  assign dist_sq = RADIUS_BITS'(sqx_q) + RADIUS_BITS'(sqy_q) + RADIUS_BITS'(sqz_q);
  assign close   = ent_valid_i && (dist_sq < radius_i);

  always_comb begin
    tok_o.valid = valid_q;
    tok_o.x     = x_q;
    tok_o.y     = y_q;
    tok_o.z     = z_q;
    tok_o.hit   = hit_q | close;
  end

endmodule

[rtl/core/waypoint_obstacle_clearance_filter.sv]
// top level of the waypoint obstacle clearance filter
// Clear and load transfers give no result, and the input stays ready after them; a load
// into a full store is dropped. A test sends the waypoint down a chain of MAX_OBSTACLES
// cells, one cell per cycle while the chain is not held, each cell holding one obstacle
// and flagging a squared distance below clearance_radius_sq; no new item is taken until
// the result has been captured in the output register, so tests do not overlap.
// The chain holds while a finished result waits at the output.
// clearance_radius_sq sits at byte address 0 of the 64-bit register port.
module waypoint_obstacle_clearance_filter #(
  parameter int MAX_OBSTACLES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wocf_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wocf_pkg::out_item_t            out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wocf_pkg::ADDR_BITS-1:0] paddr,
  input  logic [wocf_pkg::DATA_BITS-1:0] pwdata,
  output logic [wocf_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);
  import wocf_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_OBSTACLES + 1);

  logic [RADIUS_BITS-1:0] radius_q;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q;
  logic                   in_xfer, do_load, do_test, adv, capture, reg_sel;
  token_t                 tok [MAX_OBSTACLES+1];

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_BITS-1] == 1'b0);
  assign prdata  = reg_sel ? DATA_BITS'(radius_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      radius_q <= pwdata[RADIUS_BITS-1:0];
    end
  end

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    do_load = 1'b0;
    do_test = 1'b0;
    cnt_d   = cnt_q;
    if (in_xfer) begin
      case (in_item_i.opcode)
        OP_CLEAR: cnt_d = '0;
        OP_LOAD: begin
          do_load = (cnt_q < CNT_BITS'(MAX_OBSTACLES));
          if (do_load) begin
            cnt_d = cnt_q + CNT_BITS'(1);
          end
        end
        OP_TEST: do_test = 1'b1;
        default: ;
      endcase
    end
  end

  // the chain holds when its tail has a result and the output is still full
  assign adv     = !(tok[MAX_OBSTACLES].valid && out_valid_q && !out_ready_i);
  assign capture = tok[MAX_OBSTACLES].valid && adv;

  always_comb begin
    tok[0].valid = do_test;
    tok[0].x     = in_item_i.pos_x;
    tok[0].y     = in_item_i.pos_y;
    tok[0].z     = in_item_i.pos_z;
    tok[0].hit   = 1'b0;
  end

  for (genvar k = 0; k < MAX_OBSTACLES; k++) begin : g_cell
    wocf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .wr_en_i     (do_load && (cnt_q == CNT_BITS'(k))),
      .ent_valid_i (cnt_q > CNT_BITS'(k)),
      .wr_x_i      (in_item_i.pos_x),
      .wr_y_i      (in_item_i.pos_y),
      .wr_z_i      (in_item_i.pos_z),
      .radius_i    (radius_q),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1])
    );
  end

  always_comb begin
    busy_d = busy_q;
    if (do_test) begin
      busy_d = 1'b1;
    end else if (capture) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_item_q.route_x <= tok[MAX_OBSTACLES].x;
      out_item_q.route_y <= tok[MAX_OBSTACLES].y;
      out_item_q.route_z <= tok[MAX_OBSTACLES].z;
      out_item_q.keep    <= !tok[MAX_OBSTACLES].hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/core/wocf_checker.sv]
// port-level checks for the waypoint obstacle clearance filter and their bind
module wocf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input wocf_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i
);
  import wocf_pkg::*;

  // a stalled result stays on the output
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a test transfer makes the block busy
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.opcode == OP_TEST) |=> !in_ready_o)
    else $error("input taken while a test is in flight");

  // clear and load transfers never produce a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && in_ready_o && (in_item_i.opcode != OP_TEST)
    |=> !out_valid_o)
    else $error("result without a test");

endmodule

bind waypoint_obstacle_clearance_filter wocf_checker u_wocf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);
